/* src/ilist_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed ordered list package
// Sizes, command and status codes, and the struct types shared by the list.
// ----------------------------------------------------------------------------
`default_nettype none

package ilist_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int LEN_W    = 7;
	localparam int DATA_W   = 32;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_GET    = 3'd2;
	localparam logic [2:0] CMD_LOCATE = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BADPOS   = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]               command;
		logic [LEN_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] read_value;
		logic [LEN_W-1:0]         found_position;
		logic [LEN_W-1:0]         list_length;
		logic                     is_empty;
	} result_t;

	// Broadcast from the controller to every cell of the chain
	typedef struct packed {
		logic              insert;
		logic              delete;
		logic              clear;
		logic [LEN_W-1:0]  pos_m1;
		logic [LEN_W-1:0]  count;
		logic [DATA_W-1:0] value;
	} ctrl_t;

endpackage

`default_nettype wire

/* src/indexed_ordered_list.sv */
// ----------------------------------------------------------------------------
// Indexed ordered list
// The command is registered on transfer; in the find state the result and the
// done strobe are registered, and the first matching cell of the chain is
// encoded for locate. No new command is taken while busy (find state).
// Reset clears every cell to zero and the length to zero; results cannot be
// stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_ordered_list (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  ilist_pkg::item_t   item,
	output logic               done,
	output ilist_pkg::result_t result
);
	import ilist_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_FIND = 2'b10
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  count_q;
	logic [2:0]        cmd_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] rd_q;
	logic [CAPACITY-1:0] match_q;
	logic              done_q;
	result_t           result_q;

	logic              accept;
	ctrl_t             ctrl;
	logic              pos_zero;
	logic              full;
	logic              ins_bad;
	logic              rng_bad;
	logic [LEN_W-1:0]  count_d;
	logic [1:0]        status_d;
	logic [DATA_W-1:0] rd_or;
	logic [LEN_W-1:0]  found;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_rd   [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	assign accept   = start && !busy;
	assign busy     = (state_q == S_FIND);
	assign done     = done_q;
	assign result   = result_q;

	assign pos_zero = (item.position == '0);
	assign full     = (count_q >= LEN_W'(CAPACITY));
	assign ins_bad  = pos_zero || (item.position > count_q + LEN_W'(1));
	assign rng_bad  = pos_zero || (item.position > count_q);

	always_comb begin
		ctrl.insert = accept && (item.command == CMD_INSERT) && !full && !ins_bad;
		ctrl.delete = accept && (item.command == CMD_DELETE) && !rng_bad;
		ctrl.clear  = accept && (item.command == CMD_CLEAR);
		ctrl.pos_m1 = item.position - LEN_W'(1);
		ctrl.count  = count_q;
		ctrl.value  = item.value;
	end

	always_comb begin
		count_d  = count_q;
		status_d = ST_OK;
		unique case (item.command)
			CMD_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (ins_bad) begin
					status_d = ST_BADPOS;
				end else begin
					count_d = count_q + LEN_W'(1);
				end
			end
			CMD_DELETE: begin
				if (rng_bad) begin
					status_d = ST_BADPOS;
				end else begin
					count_d = count_q - LEN_W'(1);
				end
			end
			CMD_GET: begin
				if (rng_bad) begin
					status_d = ST_BADPOS;
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [DATA_W-1:0] lower_w;
			logic [DATA_W-1:0] upper_w;
			if (g == 0) begin : g_bot
				assign lower_w = '0;
			end else begin : g_mid_lo
				assign lower_w = cell_data[g-1];
			end
			if (g == CAPACITY-1) begin : g_top
				assign upper_w = '0;
			end else begin : g_mid_hi
				assign upper_w = cell_data[g+1];
			end
			ilist_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (IDX_W'(g)),
				.ctrl    (ctrl),
				.lower   (lower_w),
				.upper   (upper_w),
				.data    (cell_data[g]),
				.match   (cell_match[g]),
				.rd_part (cell_rd[g])
			);
		end
	endgenerate

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	// lowest matching cell wins
	always_comb begin
		found = '0;
		for (int i = CAPACITY-1; i >= 0; i--) begin
			if (match_q[i]) begin
				found = LEN_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= count_d;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= item.command;
			status_q <= status_d;
			match_q  <= cell_match;
			rd_q     <= (item.command == CMD_GET && !rng_bad) ? rd_or : '0;
		end
		if (state_q == S_FIND) begin
			result_q.read_value  <= rd_q;
			result_q.list_length <= count_q;
			result_q.is_empty    <= (count_q == '0);
			if (cmd_q == CMD_LOCATE) begin
				result_q.found_position <= found;
				result_q.status         <= (match_q == '0) ? ST_NOTFOUND : ST_OK;
			end else begin
				result_q.found_position <= '0;
				result_q.status         <= status_q;
			end
		end
	end

endmodule

`default_nettype wire

/* src/ilist_cell.sv */
// ----------------------------------------------------------------------------
// List cell
// Holds one element, shifts with its neighbors on insert and delete, and
// reports its match and read contributions.
// ----------------------------------------------------------------------------
`default_nettype none

module ilist_cell (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  [ilist_pkg::IDX_W-1:0]  idx,
	input  ilist_pkg::ctrl_t              ctrl,
	input  wire  [ilist_pkg::DATA_W-1:0] lower,
	input  wire  [ilist_pkg::DATA_W-1:0] upper,
	output logic [ilist_pkg::DATA_W-1:0] data,
	output logic                          match,
	output logic [ilist_pkg::DATA_W-1:0] rd_part
);
	import ilist_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;
	logic [LEN_W-1:0]  idx_ext;

	assign idx_ext = {{(LEN_W-IDX_W){1'b0}}, idx};
	assign data    = data_q;
	assign match   = (idx_ext < ctrl.count) && (data_q == ctrl.value);
	assign rd_part = (idx_ext == ctrl.pos_m1) ? data_q : '0;

	always_comb begin
		data_d = data_q;
		priority if (ctrl.clear) begin
			data_d = '0;
		end else if (ctrl.insert) begin
			if (idx_ext == ctrl.pos_m1) begin
				data_d = ctrl.value;
			end else if (idx_ext > ctrl.pos_m1) begin
				data_d = lower;
			end
		end else if (ctrl.delete) begin
			// take the upper neighbor; the top slot pulls in zero
			if (idx_ext >= ctrl.pos_m1) begin
				data_d = upper;
			end
		end else begin
			// hold
			data_d = data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			data_q <= data_d;
		end
	end

endmodule

`default_nettype wire
